FILE: src/tempo_lock_follower_unit_defines.svh
// Assertion macros shared by the tempo lock follower modules.
`ifndef TEMPO_LOCK_FOLLOWER_UNIT_DEFINES_SVH
`define TEMPO_LOCK_FOLLOWER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tlf_pkg.sv
// Types and constants shared by the tempo lock follower modules.
package tlf_pkg;

    localparam int TEMPO_W  = 9;
    localparam int CONF_W   = 8;
    localparam int COUNT_W  = 4;
    localparam int STAMP_W  = 32;
    localparam int APB_W    = 32;
    localparam int ADDR_W   = 5;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 48;

    localparam logic [TEMPO_W-1:0] TEMPO_CEIL = 9'd511;

    typedef enum logic [2:0] {
        REG_ACQUIRE_CONF = 3'd0,
        REG_FOLLOW_CONF  = 3'd1,
        REG_ONSETS_LOCK  = 3'd2,
        REG_TEMPO_TOL    = 3'd3,
        REG_SILENCE_MS   = 3'd4,
        REG_MAX_TEMPO    = 3'd5
    } reg_idx_t;

    localparam logic [CONF_W-1:0]  RST_ACQUIRE_CONF = 8'd68;
    localparam logic [CONF_W-1:0]  RST_FOLLOW_CONF  = 8'd62;
    localparam logic [COUNT_W-1:0] RST_ONSETS_LOCK  = 4'd3;
    localparam logic [TEMPO_W-1:0] RST_TEMPO_TOL    = 9'd4;
    localparam logic [STAMP_W-1:0] RST_SILENCE_MS   = 32'd4000;
    localparam logic [TEMPO_W-1:0] RST_MAX_TEMPO    = 9'd170;

    typedef struct packed {
        logic [CONF_W-1:0]  acquire_confidence;
        logic [CONF_W-1:0]  follow_confidence;
        logic [COUNT_W-1:0] onsets_to_lock;
        logic [TEMPO_W-1:0] tempo_tolerance;
        logic [STAMP_W-1:0] silence_timeout_ms;
        logic [TEMPO_W-1:0] max_tempo;
    } cfg_t;

    typedef struct packed {
        logic               show_running;
        logic               music_present;
        logic [TEMPO_W-1:0] detected_tempo;
        logic [STAMP_W-1:0] onset_time;
        logic [STAMP_W-1:0] now_time;
        logic [CONF_W-1:0]  confidence;
        logic [TEMPO_W-1:0] current_tempo;
    } in_item_t;

    typedef struct packed {
        logic               set_tempo;
        logic [TEMPO_W-1:0] tempo;
        logic               acquired;
        logic [STAMP_W-1:0] lock_onset_time;
    } out_item_t;

endpackage

FILE: src/tlf_cfg.sv
// APB register file holding the tempo lock follower configuration.
module tlf_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tlf_pkg::ADDR_W-1:0]  paddr,
    input  logic [tlf_pkg::APB_W-1:0]   pwdata,
    output logic [tlf_pkg::APB_W-1:0]   prdata,
    output logic                        pready,
    output tlf_pkg::cfg_t               cfg
);

    tlf_pkg::cfg_t     cfg_reg;
    tlf_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = tlf_pkg::reg_idx_t'(paddr[tlf_pkg::ADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.acquire_confidence <= tlf_pkg::RST_ACQUIRE_CONF;
            cfg_reg.follow_confidence  <= tlf_pkg::RST_FOLLOW_CONF;
            cfg_reg.onsets_to_lock     <= tlf_pkg::RST_ONSETS_LOCK;
            cfg_reg.tempo_tolerance    <= tlf_pkg::RST_TEMPO_TOL;
            cfg_reg.silence_timeout_ms <= tlf_pkg::RST_SILENCE_MS;
            cfg_reg.max_tempo          <= tlf_pkg::RST_MAX_TEMPO;
        end
        else if (wr_en)
        begin
            unique case (idx)
                tlf_pkg::REG_ACQUIRE_CONF:
                    cfg_reg.acquire_confidence <= pwdata[tlf_pkg::CONF_W-1:0];
                tlf_pkg::REG_FOLLOW_CONF:
                    cfg_reg.follow_confidence <= pwdata[tlf_pkg::CONF_W-1:0];
                tlf_pkg::REG_ONSETS_LOCK:
                    cfg_reg.onsets_to_lock <= pwdata[tlf_pkg::COUNT_W-1:0];
                tlf_pkg::REG_TEMPO_TOL:
                    cfg_reg.tempo_tolerance <= pwdata[tlf_pkg::TEMPO_W-1:0];
                tlf_pkg::REG_SILENCE_MS:
                    cfg_reg.silence_timeout_ms <= pwdata[tlf_pkg::STAMP_W-1:0];
                tlf_pkg::REG_MAX_TEMPO:
                    cfg_reg.max_tempo <= pwdata[tlf_pkg::TEMPO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            tlf_pkg::REG_ACQUIRE_CONF: prdata = 32'(cfg_reg.acquire_confidence);
            tlf_pkg::REG_FOLLOW_CONF:  prdata = 32'(cfg_reg.follow_confidence);
            tlf_pkg::REG_ONSETS_LOCK:  prdata = 32'(cfg_reg.onsets_to_lock);
            tlf_pkg::REG_TEMPO_TOL:    prdata = 32'(cfg_reg.tempo_tolerance);
            tlf_pkg::REG_SILENCE_MS:   prdata = 32'(cfg_reg.silence_timeout_ms);
            tlf_pkg::REG_MAX_TEMPO:    prdata = 32'(cfg_reg.max_tempo);
            default:                   prdata = '0;
        endcase
    end

endmodule

FILE: src/tlf_core.sv
// Lock state registers and the single-pass acquire/follow/silence logic.
`include "tempo_lock_follower_unit_defines.svh"

module tlf_core
#(
    parameter int TIME_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  tlf_pkg::in_item_t  item,
    input  tlf_pkg::cfg_t      cfg,
    output tlf_pkg::out_item_t res
);

    localparam int CMP_W = (TIME_BITS > tlf_pkg::STAMP_W) ? TIME_BITS : tlf_pkg::STAMP_W;

    logic [TIME_BITS-1:0]        last_onset_reg, last_onset_next;
    logic [tlf_pkg::TEMPO_W-1:0] cand_tempo_reg, cand_tempo_next;
    logic [tlf_pkg::COUNT_W-1:0] cand_count_reg, cand_count_next;
    logic [tlf_pkg::TEMPO_W-1:0] follow_tempo_reg, follow_tempo_next;
    logic [1:0]                  follow_count_reg, follow_count_next;
    logic                        locked_reg, locked_next;

    logic [TIME_BITS-1:0]        onset_w, now_w, elapsed;
    logic                        fresh, silent;
    logic [tlf_pkg::TEMPO_W-1:0] det, cur, diff, avg, step_up;
    logic [tlf_pkg::TEMPO_W:0]   avg_sum;
    logic [tlf_pkg::COUNT_W-1:0] cnt_inc;

    // Fold the 32-bit stamps into the internal time width.
    generate
        if (TIME_BITS < tlf_pkg::STAMP_W)
        begin : g_narrow
            assign onset_w = item.onset_time[TIME_BITS-1:0];
            assign now_w   = item.now_time[TIME_BITS-1:0];
        end
        else
        begin : g_wide
            assign onset_w = TIME_BITS'(item.onset_time);
            assign now_w   = TIME_BITS'(item.now_time);
        end
    endgenerate

    assign det     = item.detected_tempo;
    assign cur     = item.current_tempo;
    assign elapsed = now_w - last_onset_reg;
    assign silent  = CMP_W'(elapsed) > CMP_W'(cfg.silence_timeout_ms);
    assign fresh   = item.music_present && (det != '0) && (onset_w != '0)
                     && (onset_w != last_onset_reg);
    assign diff    = (cand_tempo_reg > det) ? cand_tempo_reg - det : det - cand_tempo_reg;
    assign avg_sum = {1'b0, cand_tempo_reg} + {1'b0, det} + 10'd1;
    assign avg     = avg_sum[tlf_pkg::TEMPO_W:1];
    assign cnt_inc = (cand_count_reg < cfg.onsets_to_lock) ? cand_count_reg + 4'd1
                                                           : cand_count_reg;
    assign step_up = (cur == tlf_pkg::TEMPO_CEIL) ? tlf_pkg::TEMPO_CEIL : cur + 9'd1;

    always_comb
    begin
        last_onset_next   = last_onset_reg;
        cand_tempo_next   = cand_tempo_reg;
        cand_count_next   = cand_count_reg;
        follow_tempo_next = follow_tempo_reg;
        follow_count_next = follow_count_reg;
        locked_next       = locked_reg;
        res               = '0;

        if (!item.show_running)
        begin
            last_onset_next   = '0;
            cand_tempo_next   = '0;
            cand_count_next   = '0;
            follow_tempo_next = '0;
            follow_count_next = '0;
            locked_next       = 1'b0;
        end
        else if (det > cfg.max_tempo)
        begin
            // too fast: ignore the item entirely
        end
        else if (!fresh)
        begin
            if (locked_reg && silent)
            begin
                last_onset_next   = '0;
                cand_tempo_next   = '0;
                cand_count_next   = '0;
                follow_tempo_next = '0;
                follow_count_next = '0;
                locked_next       = 1'b0;
            end
        end
        else
        begin
            last_onset_next = onset_w;
            if (!locked_reg)
            begin
                if (item.confidence < cfg.acquire_confidence)
                begin
                    cand_count_next = '0;
                    cand_tempo_next = '0;
                end
                else if (cand_count_reg == '0 || diff > cfg.tempo_tolerance)
                begin
                    cand_tempo_next = det;
                    cand_count_next = 4'd1;
                end
                else
                begin
                    cand_tempo_next = avg;
                    cand_count_next = cnt_inc;
                    if (cnt_inc >= cfg.onsets_to_lock)
                    begin
                        locked_next         = 1'b1;
                        follow_tempo_next   = '0;
                        follow_count_next   = '0;
                        res.set_tempo       = 1'b1;
                        res.tempo           = avg;
                        res.acquired        = 1'b1;
                        res.lock_onset_time = tlf_pkg::STAMP_W'(onset_w);
                    end
                end
            end
            else if (item.confidence >= cfg.follow_confidence)
            begin
                if (det == cur)
                begin
                    follow_tempo_next = '0;
                    follow_count_next = '0;
                end
                else if (follow_count_reg == '0 || follow_tempo_reg != det)
                begin
                    follow_tempo_next = det;
                    follow_count_next = 2'd1;
                end
                else
                begin
                    res.set_tempo     = 1'b1;
                    res.tempo         = (det > cur) ? step_up : cur - 9'd1;
                    follow_tempo_next = '0;
                    follow_count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_onset_reg   <= '0;
            cand_tempo_reg   <= '0;
            cand_count_reg   <= '0;
            follow_tempo_reg <= '0;
            follow_count_reg <= '0;
            locked_reg       <= 1'b0;
        end
        else if (fire)
        begin
            last_onset_reg   <= last_onset_next;
            cand_tempo_reg   <= cand_tempo_next;
            cand_count_reg   <= cand_count_next;
            follow_tempo_reg <= follow_tempo_next;
            follow_count_reg <= follow_count_next;
            locked_reg       <= locked_next;
        end
    end

    `TLF_ASSERT_NEXT(a_stop_clears, clk, rst_n, fire && !item.show_running, !locked_reg && cand_count_reg == '0 && last_onset_reg == '0, "stopped show left lock state behind")
    `TLF_ASSERT_NOW(a_lock_via_acquire, clk, rst_n, $rose(locked_reg), $past(fire && res.acquired), "lock set without an acquiring item")

endmodule

FILE: src/tempo_lock_follower_unit.sv
// Top level of the tempo lock follower: stream ports, item registers, APB port.
// An accepted item is held in the input register, then its result in the result
//   register; the lock logic sits combinationally between the two.
// Throughput: one item per cycle unless the result is stalled; tlf_core updates its state once per item.
// Input ready drops only while both item registers are full and the result is stalled.
// Reset (rst_n low, asynchronous): empties both item registers, clears the lock
//   state and loads the configuration registers with their defaults.
`include "tempo_lock_follower_unit_defines.svh"

module tempo_lock_follower_unit
#(
    parameter int TIME_BITS = 32
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // slave side
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] show_running, [1] music_present, [10:2] detected_tempo,
    // [42:11] onset_time, [74:43] now_time, [82:75] confidence,
    // [91:83] current_tempo, [95:92] zero
    input  logic [tlf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // master side
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] set_tempo, [9:1] tempo, [10] acquired, [42:11] lock_onset_time,
    // [47:43] zero
    output logic [tlf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tlf_pkg::ADDR_W-1:0]        paddr,
    input  logic [tlf_pkg::APB_W-1:0]         pwdata,
    output logic [tlf_pkg::APB_W-1:0]         prdata,
    output logic                              pready
);

    tlf_pkg::cfg_t      cfg;
    tlf_pkg::in_item_t  in_item_reg;
    tlf_pkg::out_item_t res;
    tlf_pkg::out_item_t out_item_reg;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               in_take;

    // The result register frees up when empty or when its item is taken;
    // the input register moves into it in that same cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_item_reg.lock_onset_time, out_item_reg.acquired,
                            out_item_reg.tempo, out_item_reg.set_tempo};

    tlf_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tlf_core #(.TIME_BITS(TIME_BITS)) u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Control: valid flags of both item registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: unpack on entry, hold the result until taken.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.show_running   <= s_axis_tdata[0];
            in_item_reg.music_present  <= s_axis_tdata[1];
            in_item_reg.detected_tempo <= s_axis_tdata[10:2];
            in_item_reg.onset_time     <= s_axis_tdata[42:11];
            in_item_reg.now_time       <= s_axis_tdata[74:43];
            in_item_reg.confidence     <= s_axis_tdata[82:75];
            in_item_reg.current_tempo  <= s_axis_tdata[91:83];
        end
        if (advance)
        begin
            out_item_reg <= res;
        end
    end

    `TLF_ASSERT_NOW(a_ready_only_on_stall, clk, rst_n, !s_axis_tready, in_valid_reg && out_valid_reg && !m_axis_tready, "input stalled without a stalled result")
    `TLF_ASSERT_NOW(a_acquire_sets_tempo, clk, rst_n, out_valid_reg && out_item_reg.acquired, out_item_reg.set_tempo && out_item_reg.tempo != '0, "acquired item without a tempo")

endmodule

FILE: tb/tempo_follow_checker.sv
// Checker for the tempo lock follower: watches both streams and the register port.
module tempo_follow_checker
    import tlf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    // [0] show_running, [1] music_present, [10:2] detected_tempo, [42:11] onset_time,
    // [74:43] now_time, [82:75] confidence, [91:83] current_tempo, [95:92] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] set_tempo, [9:1] tempo, [10] acquired, [42:11] lock_onset_time, [47:43] zero
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_W-1:0]      pwdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t               regs;
    logic [STAMP_W-1:0] last_onset;
    logic [TEMPO_W-1:0] cand_tempo;
    logic [COUNT_W-1:0] cand_count;
    logic [TEMPO_W-1:0] follow_tempo;
    logic [1:0]         follow_count;
    logic               locked;
    out_item_t          tempo_commands_due[$];

    function automatic void clear_lock_state();
        last_onset   = '0;
        cand_tempo   = '0;
        cand_count   = '0;
        follow_tempo = '0;
        follow_count = '0;
        locked       = 1'b0;
    endfunction

    // Advance the lock state by one observation and return the tempo command it causes.
    function automatic out_item_t predict_tempo_command(input in_item_t obs);
        out_item_t          cmd;
        logic               fresh;
        logic [STAMP_W-1:0] quiet_ms;
        logic [TEMPO_W-1:0] spread;
        logic [TEMPO_W:0]   pair_sum;
        cmd = '0;
        if (!obs.show_running)
        begin
            clear_lock_state();
            return cmd;
        end
        fresh = obs.music_present && obs.detected_tempo != 0 && obs.onset_time != 0
                && obs.onset_time != last_onset;
        if (obs.detected_tempo > regs.max_tempo)
            return cmd;
        if (!fresh)
        begin
            quiet_ms = obs.now_time - last_onset;
            if (locked && quiet_ms > regs.silence_timeout_ms)
                clear_lock_state();
            return cmd;
        end
        last_onset = obs.onset_time;

        if (!locked)
        begin
            if (obs.confidence < regs.acquire_confidence)
            begin
                cand_count = '0;
                cand_tempo = '0;
                return cmd;
            end
            spread = (cand_tempo > obs.detected_tempo) ? cand_tempo - obs.detected_tempo
                                                       : obs.detected_tempo - cand_tempo;
            if (cand_count == 0 || spread > regs.tempo_tolerance)
            begin
                cand_tempo = obs.detected_tempo;
                cand_count = 1;
                return cmd;
            end
            pair_sum   = cand_tempo + obs.detected_tempo + 1'b1;
            cand_tempo = pair_sum[TEMPO_W:1];
            if (cand_count < regs.onsets_to_lock)
                cand_count = cand_count + 1'b1;
            if (cand_count < regs.onsets_to_lock)
                return cmd;
            locked              = 1'b1;
            cmd.set_tempo       = 1'b1;
            cmd.tempo           = cand_tempo;
            cmd.acquired        = 1'b1;
            cmd.lock_onset_time = obs.onset_time;
            follow_tempo        = '0;
            follow_count        = '0;
            return cmd;
        end

        if (obs.confidence < regs.follow_confidence)
            return cmd;
        if (obs.detected_tempo == obs.current_tempo)
        begin
            follow_tempo = '0;
            follow_count = '0;
            return cmd;
        end
        if (follow_count == 0 || follow_tempo != obs.detected_tempo)
        begin
            follow_tempo = obs.detected_tempo;
            follow_count = 1;
            return cmd;
        end
        cmd.set_tempo = 1'b1;
        if (obs.detected_tempo > obs.current_tempo)
            cmd.tempo = (obs.current_tempo == TEMPO_CEIL) ? TEMPO_CEIL
                                                           : obs.current_tempo + 1'b1;
        else
            cmd.tempo = obs.current_tempo - 1'b1;
        follow_tempo = '0;
        follow_count = '0;
        return cmd;
    endfunction

    function automatic void check_field(input string field, input logic [STAMP_W-1:0] expected,
                                        input logic [STAMP_W-1:0] actual);
        if (actual !== expected)
        begin
            $error("%s: expected %0d, got %0d", field, expected, actual);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        in_item_t  obs;
        out_item_t got;
        out_item_t want;
        if (!rst_n)
        begin
            regs = '{RST_ACQUIRE_CONF, RST_FOLLOW_CONF, RST_ONSETS_LOCK, RST_TEMPO_TOL,
                     RST_SILENCE_MS, RST_MAX_TEMPO};
            clear_lock_state();
            tempo_commands_due.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_ACQUIRE_CONF: regs.acquire_confidence = pwdata[CONF_W-1:0];
                    REG_FOLLOW_CONF:  regs.follow_confidence  = pwdata[CONF_W-1:0];
                    REG_ONSETS_LOCK:  regs.onsets_to_lock     = pwdata[COUNT_W-1:0];
                    REG_TEMPO_TOL:    regs.tempo_tolerance    = pwdata[TEMPO_W-1:0];
                    REG_SILENCE_MS:   regs.silence_timeout_ms = pwdata[STAMP_W-1:0];
                    REG_MAX_TEMPO:    regs.max_tempo          = pwdata[TEMPO_W-1:0];
                    default: ;
                endcase
            end

            // Retire before predicting so a result never matches an item taken this cycle.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.set_tempo       = m_axis_tdata[0];
                got.tempo           = m_axis_tdata[9:1];
                got.acquired        = m_axis_tdata[10];
                got.lock_onset_time = m_axis_tdata[42:11];
                if (tempo_commands_due.size() == 0)
                begin
                    $error("result with no item outstanding: tdata %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = tempo_commands_due.pop_front();
                    check_field("set_tempo", want.set_tempo, got.set_tempo);
                    check_field("tempo", want.tempo, got.tempo);
                    check_field("acquired", want.acquired, got.acquired);
                    check_field("lock_onset_time", want.lock_onset_time, got.lock_onset_time);
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                obs.show_running   = s_axis_tdata[0];
                obs.music_present  = s_axis_tdata[1];
                obs.detected_tempo = s_axis_tdata[10:2];
                obs.onset_time     = s_axis_tdata[42:11];
                obs.now_time       = s_axis_tdata[74:43];
                obs.confidence     = s_axis_tdata[82:75];
                obs.current_tempo  = s_axis_tdata[91:83];
                tempo_commands_due.push_back(predict_tempo_command(obs));
            end

            pending = tempo_commands_due.size();
        end
    end

endmodule

FILE: tb/testbench.sv
// Top of the tempo lock follower testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tlf_pkg::*;

    // Quiet cycles after the last result; the block answers through its input and result registers.
    localparam int DRAIN_CYCLES = 6;
    // Cycles with no item moving on either stream before the run is declared hung.
    localparam int STUCK_LIMIT  = 1000;
    // Length of the deliberate long receiver hold-off.
    localparam int HOLD_CYCLES  = 60;
    localparam int PHASES       = 7;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [0] show_running, [1] music_present, [10:2] detected_tempo, [42:11] onset_time,
    // [74:43] now_time, [82:75] confidence, [91:83] current_tempo, [95:92] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [0] set_tempo, [9:1] tempo, [10] acquired, [42:11] lock_onset_time, [47:43] zero
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [APB_W-1:0]      pwdata;
    logic [APB_W-1:0]      prdata;
    logic                  pready;

    int fail_count;
    int pending;

    // Idle percentages for each side, and the long hold-off handshake with the receiver.
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_request;
    bit hold_served;

    // Settings in force, kept to aim the stimulus at thresholds.
    cfg_t               active;
    logic [STAMP_W-1:0] onset_clock;
    logic [TEMPO_W-1:0] base_tempo;
    logic [TEMPO_W-1:0] prev_det;
    int                 phase_items[PHASES] = '{80, 60, 80, 80, 80, 20, 80};

    tempo_lock_follower_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    tempo_follow_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: stall at random, and once serve a long hold-off so the block backs up
    // into its input while the sender keeps offering items.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_served)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_served = 1'b1;
            end
            m_axis_tready <= !(rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct);
        end
    end

    // Watchdog: end the run if no item moves on either stream for too long.
    initial
    begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stuck = 0;
            else
                stuck++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic in_item_t observation(input logic run, input logic music,
                                             input int det, input logic [STAMP_W-1:0] onset,
                                             input logic [STAMP_W-1:0] now, input int conf,
                                             input int cur);
        in_item_t obs;
        obs.show_running   = run;
        obs.music_present  = music;
        obs.detected_tempo = TEMPO_W'(det);
        obs.onset_time     = onset;
        obs.now_time       = now;
        obs.confidence     = CONF_W'(conf);
        obs.current_tempo  = TEMPO_W'(cur);
        return obs;
    endfunction

    // Offer one item, idling the sender first at random, and hold it until taken.
    // Valid stays high on return; the caller drops it before any wait.
    task automatic send_item(input in_item_t obs);
        @(negedge clk);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, obs.current_tempo, obs.confidence, obs.now_time,
                          obs.onset_time, obs.detected_tempo, obs.music_present,
                          obs.show_running};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipeline drain.
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the access edge.
    task automatic write_register(input reg_idx_t idx, input logic [APB_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mostly fresh onsets around a drifting base tempo, with readings often repeated so
    // the lock and the follower both get exercised; the rest probes stale onsets, the
    // silence edge, stopped shows, over-fast tempos and plain noise.
    task automatic send_random_observation();
        in_item_t obs;
        int       kind;
        int       det;
        int       pick;
        kind = $urandom_range(99);
        if ($urandom_range(29) == 0)
            base_tempo = TEMPO_W'($urandom_range(1, (active.max_tempo == 0) ? 60
                                                                         : active.max_tempo));
        if (prev_det != 0 && $urandom_range(1) == 0)
            det = prev_det;
        else
        begin
            det = int'(base_tempo) + int'($urandom_range(4)) - 2;
            if (det < 1)
                det = 1;
            if (det > 511)
                det = 511;
        end
        pick = $urandom_range(9);
        obs.show_running   = 1'b1;
        obs.music_present  = 1'b1;
        obs.detected_tempo = TEMPO_W'(det);
        obs.confidence     = (pick < 3) ? 8'd255
                           : (pick < 9) ? CONF_W'($urandom_range(160, 254))
                                        : CONF_W'($urandom_range(255));
        pick = $urandom_range(9);
        obs.current_tempo  = (pick < 7) ? base_tempo
                           : (pick < 8) ? TEMPO_W'(det) : TEMPO_W'($urandom_range(511));
        obs.onset_time     = onset_clock;
        obs.now_time       = onset_clock + $urandom_range(3000);

        if (kind < 60 || (kind >= 80 && kind < 85))
        begin
            // advance to a fresh onset; hop over zero, which means no onset
            onset_clock = onset_clock + $urandom_range(200, 800);
            if (onset_clock == 0)
                onset_clock = 1;
            obs.onset_time = onset_clock;
            obs.now_time   = onset_clock + $urandom_range(50);
            if (kind < 60)
                prev_det = TEMPO_W'(det);
            else if (active.max_tempo != TEMPO_CEIL)
                obs.detected_tempo = TEMPO_W'($urandom_range(int'(active.max_tempo) + 1, 511));
        end
        else if (kind < 75 && kind >= 68)
        begin
            // land right on the silence limit or one past it
            obs.music_present = 1'($urandom_range(1));
            obs.now_time      = onset_clock + active.silence_timeout_ms + $urandom_range(1);
        end
        else if (kind >= 75 && kind < 80)
        begin
            obs.show_running   = 1'b0;
            obs.detected_tempo = TEMPO_W'($urandom_range(511));
            obs.onset_time     = $urandom;
            obs.now_time       = $urandom;
        end
        else if (kind >= 85)
        begin
            obs.show_running   = ($urandom_range(7) != 0);
            obs.music_present  = 1'($urandom_range(1));
            obs.detected_tempo = TEMPO_W'($urandom_range(511));
            obs.onset_time     = $urandom;
            obs.now_time       = $urandom;
            obs.confidence     = CONF_W'($urandom_range(255));
            obs.current_tempo  = TEMPO_W'($urandom_range(511));
        end
        send_item(obs);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        hold_request  = 1'b0;
        hold_served   = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed pass under the reset settings: acquire 68, follow 62, three onsets,
        // tolerance 4, silence 4000 ms, ceiling 170.
        // stopped show with every field at its top value
        send_item(observation(1'b0, 1'b1, 511, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 255, 511));
        // no tempo, no onset, no music: none of these is a fresh onset
        send_item(observation(1'b1, 1'b1, 0, 32'd900, 32'd900, 200, 120));
        send_item(observation(1'b1, 1'b1, 120, 32'd0, 32'd950, 200, 120));
        send_item(observation(1'b1, 1'b0, 120, 32'd960, 32'd960, 200, 120));
        // one past the ceiling is ignored outright
        send_item(observation(1'b1, 1'b1, 171, 32'd980, 32'd980, 200, 120));
        // confidence one short of the acquire threshold
        send_item(observation(1'b1, 1'b1, 120, 32'd1000, 32'd1000, 67, 120));
        // start a candidate, break it with a far reading, then agree up to lock
        send_item(observation(1'b1, 1'b1, 120, 32'd1100, 32'd1100, 68, 120));
        send_item(observation(1'b1, 1'b1, 130, 32'd1150, 32'd1150, 68, 120));
        send_item(observation(1'b1, 1'b1, 126, 32'd1200, 32'd1200, 68, 120));
        send_item(observation(1'b1, 1'b1, 126, 32'd1200, 32'd1210, 68, 120));
        send_item(observation(1'b1, 1'b1, 130, 32'd1300, 32'd1300, 68, 120));
        // locked at 129: a weak reading is skipped, two equal ones step up
        send_item(observation(1'b1, 1'b1, 150, 32'd1400, 32'd1400, 61, 129));
        send_item(observation(1'b1, 1'b1, 135, 32'd1500, 32'd1500, 62, 129));
        send_item(observation(1'b1, 1'b1, 135, 32'd1600, 32'd1600, 62, 129));
        // differing readings restart the follower, then two equal ones step down
        send_item(observation(1'b1, 1'b1, 120, 32'd1700, 32'd1700, 62, 130));
        send_item(observation(1'b1, 1'b1, 121, 32'd1800, 32'd1800, 62, 130));
        send_item(observation(1'b1, 1'b1, 121, 32'd1900, 32'd1900, 62, 130));
        // reading equal to the running tempo clears the follower
        send_item(observation(1'b1, 1'b1, 130, 32'd2000, 32'd2000, 62, 130));
        // silence exactly at the limit keeps the lock, one more millisecond drops it
        send_item(observation(1'b1, 1'b0, 100, 32'd0, 32'd6000, 62, 130));
        send_item(observation(1'b1, 1'b0, 100, 32'd0, 32'd6001, 62, 130));
        // tempo exactly at the ceiling with the latest possible onset
        send_item(observation(1'b1, 1'b1, 170, 32'hFFFF_FFFF, 32'd5, 255, 0));
        send_item(observation(1'b0, 1'b0, 0, 32'd0, 32'd0, 0, 0));

        // Random phases, each under its own settings and idling pattern.
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0: active = '{8'd0, 8'd0, 4'd1, 9'd0, 32'd0, 9'd511};
                1: active = '{8'd255, 8'd255, 4'd15, 9'd511, 32'hFFFF_FFFF, 9'd511};
                2: active = '{8'd100, 8'd90, 4'd0, 9'd8, 32'd1500, 9'd250};
                3: active = '{RST_ACQUIRE_CONF, RST_FOLLOW_CONF, RST_ONSETS_LOCK,
                              RST_TEMPO_TOL, RST_SILENCE_MS, RST_MAX_TEMPO};
                5: active = '{8'd50, 8'd40, 4'd2, 9'd6, 32'd800, 9'd0};
                default:
                begin
                    active.acquire_confidence = CONF_W'($urandom_range(40, 200));
                    active.follow_confidence  = CONF_W'($urandom_range(30, 200));
                    active.onsets_to_lock     = COUNT_W'($urandom_range(1, 6));
                    active.tempo_tolerance    = TEMPO_W'($urandom_range(12));
                    active.silence_timeout_ms = STAMP_W'($urandom_range(500, 5000));
                    active.max_tempo          = TEMPO_W'($urandom_range(120, 511));
                end
            endcase
            write_register(REG_ACQUIRE_CONF, APB_W'(active.acquire_confidence));
            write_register(REG_FOLLOW_CONF, APB_W'(active.follow_confidence));
            write_register(REG_ONSETS_LOCK, APB_W'(active.onsets_to_lock));
            write_register(REG_TEMPO_TOL, APB_W'(active.tempo_tolerance));
            write_register(REG_SILENCE_MS, APB_W'(active.silence_timeout_ms));
            write_register(REG_MAX_TEMPO, APB_W'(active.max_tempo));

            // none, sender idling, receiver stalling, both lightly
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
                1: begin tx_idle_pct = 48; rx_idle_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_idle_pct = 48; end
                default: begin tx_idle_pct = 7; rx_idle_pct = 7; end
            endcase

            onset_clock = $urandom;
            prev_det    = '0;
            base_tempo  = TEMPO_W'($urandom_range(1, (active.max_tempo == 0) ? 60
                                                                          : active.max_tempo));
            for (int i = 0; i < phase_items[p]; i++)
            begin
                // in the unthrottled random phase: back the block up once, and later
                // pause the sender until every result is home
                if (p == 4 && i == 20)
                    hold_request = 1'b1;
                if (p == 4 && i == 50)
                    settle();
                send_random_observation();
            end
        end

        settle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
